FILE: hdl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types and character codes for the principal name splitter.
// ----------------------------------------------------------------------------
package pns_pkg;

  typedef enum logic [1:0] {
    FIELD_NAME  = 2'd0,
    FIELD_INST  = 2'd1,
    FIELD_REALM = 2'd2
  } field_t;

  localparam logic [7:0] CH_ESCAPE = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_AT     = 8'h40;

  typedef struct packed {
    logic       write_enable;
    logic [1:0] field_sel;
    logic [5:0] position;
    logic [7:0] char_out;
    logic       close_field;
    logic       clear_instance;
    logic       error;
    logic       done_res;
  } result_t;

endpackage

FILE: hdl/pns_if.sv
// ----------------------------------------------------------------------------
// pns_in_if / pns_out_if
// Valid/ready channels for name characters and field store commands.
// ----------------------------------------------------------------------------
interface pns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_name;

  modport source (output valid, output char_in, output end_of_name, input ready);
  modport sink   (input valid, input char_in, input end_of_name, output ready);
endinterface

interface pns_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [1:0] field_sel;
  logic [5:0] position;
  logic [7:0] char_out;
  logic       close_field;
  logic       clear_instance;
  logic       error;
  logic       done_res;

  modport source (output valid, output write_enable, output field_sel, output position,
                  output char_out, output close_field, output clear_instance,
                  output error, output done_res, input ready);
  modport sink   (input valid, input write_enable, input field_sel, input position,
                  input char_out, input close_field, input clear_instance,
                  input error, input done_res, output ready);
endinterface

FILE: hdl/principal_name_splitter_top.sv
// ----------------------------------------------------------------------------
// principal_name_splitter_top
// Splits a name.instance@realm character stream into field store commands.
// ----------------------------------------------------------------------------
// Every input transaction (one character or the end marker) yields exactly one
// result transaction. The block sustains one transaction per cycle: the item
// sits in an input register, the parse state update and result are computed
// in one short combinational step, and the result lands in an output register.
// The parse state (field, length, escape, error) is a handful of small counters
// and flags updated once per item. A stalled output holds an item waiting in
// the input stage until the output register can take it.
// ----------------------------------------------------------------------------
module principal_name_splitter_top #(
  parameter int NAME_SIZE     = 40,
  parameter int INSTANCE_SIZE = 40,
  parameter int REALM_SIZE    = 40,
  parameter int FULL_SIZE     = 123
) (
  input  logic clk,
  input  logic rst_n,
  pns_in_if.sink    in_ch,
  pns_out_if.source out_ch
);

  localparam int MAX_AB   = (NAME_SIZE > INSTANCE_SIZE) ? NAME_SIZE : INSTANCE_SIZE;
  localparam int MAX_SIZE = (MAX_AB > REALM_SIZE) ? MAX_AB : REALM_SIZE;
  localparam int FLW      = $clog2(MAX_SIZE + 1);
  localparam int TLW      = $clog2(FULL_SIZE + 2);
  localparam int PW       = (FLW > 6) ? FLW : 6;

  logic                 s1_valid_r;
  logic [7:0]           s1_char_r;
  logic                 s1_end_r;
  logic                 out_valid_r;
  pns_pkg::result_t     out_r;
  pns_pkg::result_t     res_nxt;

  pns_pkg::field_t      cur_field_r, cur_field_nxt;
  logic                 esc_r, esc_nxt;
  logic [FLW-1:0]       field_len_r, field_len_nxt;
  logic [TLW-1:0]       total_len_r, total_len_nxt;
  logic                 failed_r, failed_nxt;
  logic                 adv;
  logic                 fail;

  function automatic logic [FLW-1:0] size_of(pns_pkg::field_t f);
    logic [FLW-1:0] s;
    unique case (f)
      pns_pkg::FIELD_NAME:  s = FLW'(NAME_SIZE);
      pns_pkg::FIELD_INST:  s = FLW'(INSTANCE_SIZE);
      pns_pkg::FIELD_REALM: s = FLW'(REALM_SIZE);
      default:              s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] pos_of(logic [FLW-1:0] v);
    logic [PW-1:0] e;
    e = PW'(v);
    return e[5:0];
  endfunction

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_comb begin
    res_nxt       = '0;
    cur_field_nxt = cur_field_r;
    esc_nxt       = esc_r;
    field_len_nxt = field_len_r;
    total_len_nxt = total_len_r;
    failed_nxt    = failed_r;
    fail          = 1'b0;
    if (s1_end_r) begin
      res_nxt.done_res = 1'b1;
      res_nxt.error    = failed_r;
      if (!failed_r) begin
        res_nxt.close_field = 1'b1;
        res_nxt.field_sel   = 2'(cur_field_r);
        res_nxt.position    = pos_of(field_len_r);
      end
      cur_field_nxt = pns_pkg::FIELD_NAME;
      esc_nxt       = 1'b0;
      field_len_nxt = '0;
      total_len_nxt = '0;
      failed_nxt    = 1'b0;
    end else begin
      if (!failed_r) begin
        if (total_len_r <= TLW'(FULL_SIZE)) total_len_nxt = total_len_r + 1'b1;
        if (total_len_nxt > TLW'(FULL_SIZE)) fail = 1'b1;
      end
      if (!failed_r && !fail) begin
        priority if (cur_field_r != pns_pkg::FIELD_NAME && cur_field_r != pns_pkg::FIELD_INST
                     && cur_field_r != pns_pkg::FIELD_REALM) begin
          fail = 1'b1;
        end else if (esc_r || (s1_char_r != pns_pkg::CH_ESCAPE &&
                               s1_char_r != pns_pkg::CH_AT &&
                               (s1_char_r != pns_pkg::CH_DOT ||
                                cur_field_r != pns_pkg::FIELD_NAME))) begin
          esc_nxt              = 1'b0;
          res_nxt.write_enable = 1'b1;
          res_nxt.field_sel    = 2'(cur_field_r);
          res_nxt.position     = pos_of(field_len_r);
          res_nxt.char_out     = s1_char_r;
          field_len_nxt        = field_len_r + 1'b1;
        end else if (s1_char_r == pns_pkg::CH_ESCAPE) begin
          esc_nxt = 1'b1;
        end else if (s1_char_r == pns_pkg::CH_DOT) begin
          if (field_len_r == '0) begin
            fail = 1'b1;
          end else begin
            res_nxt.close_field = 1'b1;
            res_nxt.field_sel   = 2'(pns_pkg::FIELD_NAME);
            res_nxt.position    = pos_of(field_len_r);
            cur_field_nxt       = pns_pkg::FIELD_INST;
            field_len_nxt       = '0;
          end
        end else begin
          if (cur_field_r == pns_pkg::FIELD_REALM ||
              (cur_field_r == pns_pkg::FIELD_NAME && field_len_r == '0)) begin
            fail = 1'b1;
          end else begin
            res_nxt.close_field    = 1'b1;
            res_nxt.field_sel      = 2'(cur_field_r);
            res_nxt.position       = pos_of(field_len_r);
            res_nxt.clear_instance = (cur_field_r == pns_pkg::FIELD_NAME);
            cur_field_nxt          = pns_pkg::FIELD_REALM;
            field_len_nxt          = '0;
          end
        end
        if (!fail && field_len_nxt >= size_of(cur_field_nxt)) fail = 1'b1;
      end
      failed_nxt = failed_r || fail;
      if (failed_nxt) begin
        res_nxt = '0;
      end
      res_nxt.error = failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_field_r <= pns_pkg::FIELD_NAME;
      esc_r       <= 1'b0;
      field_len_r <= '0;
      total_len_r <= '0;
      failed_r    <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (adv) begin
        out_valid_r <= 1'b1;
        cur_field_r <= cur_field_nxt;
        esc_r       <= esc_nxt;
        field_len_r <= field_len_nxt;
        total_len_r <= total_len_nxt;
        failed_r    <= failed_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_in;
      s1_end_r  <= in_ch.end_of_name;
    end
    if (adv) out_r <= res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.write_enable   = out_r.write_enable;
  assign out_ch.field_sel      = out_r.field_sel;
  assign out_ch.position       = out_r.position;
  assign out_ch.char_out       = out_r.char_out;
  assign out_ch.close_field    = out_r.close_field;
  assign out_ch.clear_instance = out_r.clear_instance;
  assign out_ch.error          = out_r.error;
  assign out_ch.done_res       = out_r.done_res;

`ifndef SYNTHESIS
  a_we_close_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.write_enable && out_r.close_field))
    else $error("write and close in one transaction");

  a_done_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res && !out_r.error) |-> out_r.close_field)
    else $error("clean end transaction without field close");

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(adv && s1_end_r)) |=> failed_r)
    else $error("error flag dropped before end transaction");

  a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_end_r) |=> (cur_field_r == pns_pkg::FIELD_NAME && field_len_r == '0
                           && total_len_r == '0 && !failed_r && !esc_r))
    else $error("parse state not rearmed after end transaction");
`endif

endmodule

FILE: bench/tb_principal_name_splitter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_principal_name_splitter_top
// Self-checking bench for the principal name splitter. Character streams
// (directed names, random well-formed names, broken names and noise) go in
// through the input channel with random gaps. A scoreboard predicts the field
// store command of every accepted transaction and checks it against the
// result channel, which is stalled at random and once held off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_principal_name_splitter_top;

  localparam int NAME_SIZE     = 40;
  localparam int INSTANCE_SIZE = 40;
  localparam int REALM_SIZE    = 40;
  localparam int FULL_SIZE     = 123;

  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 1000;
  localparam int TAIL_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst_n;

  pns_in_if  in_ch();
  pns_out_if out_ch();

  principal_name_splitter_top #(
    .NAME_SIZE     (NAME_SIZE),
    .INSTANCE_SIZE (INSTANCE_SIZE),
    .REALM_SIZE    (REALM_SIZE),
    .FULL_SIZE     (FULL_SIZE)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // parse state of the scoreboard
  pns_pkg::field_t cur_field;
  logic            esc_pending;
  int unsigned     fld_len;
  int unsigned     tot_len;
  logic            name_failed;

  pns_pkg::result_t expected_cmds[$];
  int               items_sent;
  int               mismatches;
  bit               fast_mode;
  int               hold_requests;
  int               holds_done;
  pns_pkg::result_t mon_got;
  pns_pkg::result_t mon_want;

  function automatic int unsigned field_limit(input pns_pkg::field_t f);
    case (f)
      pns_pkg::FIELD_NAME: return NAME_SIZE;
      pns_pkg::FIELD_INST: return INSTANCE_SIZE;
      default:             return REALM_SIZE;
    endcase
  endfunction

  function automatic void clear_parse();
    cur_field   = pns_pkg::FIELD_NAME;
    esc_pending = 1'b0;
    fld_len     = 0;
    tot_len     = 0;
    name_failed = 1'b0;
  endfunction

  function automatic pns_pkg::result_t predict_split(input logic [7:0] c, input logic eon);
    pns_pkg::result_t r;
    logic             fail;
    logic             store;
    r     = '0;
    fail  = 1'b0;
    store = 1'b0;
    if (eon) begin
      r.done_res = 1'b1;
      r.error    = name_failed;
      if (!name_failed) begin
        r.close_field = 1'b1;
        r.field_sel   = cur_field;
        r.position    = 6'(fld_len);
      end
      clear_parse();
      return r;
    end
    if (!name_failed) begin
      if (tot_len <= FULL_SIZE) tot_len++;
      if (tot_len > FULL_SIZE) fail = 1'b1;
    end
    if (!name_failed && !fail) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
        store       = 1'b1;
      end else if (c == pns_pkg::CH_ESCAPE) begin
        esc_pending = 1'b1;
      end else if (c == pns_pkg::CH_DOT && cur_field == pns_pkg::FIELD_NAME) begin
        if (fld_len == 0) begin
          fail = 1'b1;
        end else begin
          r.close_field = 1'b1;
          r.field_sel   = pns_pkg::FIELD_NAME;
          r.position    = 6'(fld_len);
          cur_field     = pns_pkg::FIELD_INST;
          fld_len       = 0;
        end
      end else if (c == pns_pkg::CH_AT) begin
        if (cur_field == pns_pkg::FIELD_REALM ||
            (cur_field == pns_pkg::FIELD_NAME && fld_len == 0)) begin
          fail = 1'b1;
        end else begin
          r.close_field    = 1'b1;
          r.field_sel      = cur_field;
          r.position       = 6'(fld_len);
          r.clear_instance = (cur_field == pns_pkg::FIELD_NAME);
          cur_field        = pns_pkg::FIELD_REALM;
          fld_len          = 0;
        end
      end else begin
        store = 1'b1;
      end
      if (store) begin
        r.write_enable = 1'b1;
        r.field_sel    = cur_field;
        r.position     = 6'(fld_len);
        r.char_out     = c;
        fld_len++;
      end
      if (!fail && fld_len >= field_limit(cur_field)) fail = 1'b1;
    end
    if (fail) name_failed = 1'b1;
    if (name_failed) begin
      r       = '0;
      r.error = 1'b1;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == pns_pkg::CH_ESCAPE || c == pns_pkg::CH_DOT || c == pns_pkg::CH_AT);
    return c;
  endfunction

  function automatic int pick_len(input bit long_fields);
    int r;
    r = $urandom_range(0, 99);
    if (long_fields || r >= 88) return $urandom_range(35, 41);
    if (r < 4) return 0;
    return $urandom_range(1, 8);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input pns_pkg::result_t got, input pns_pkg::result_t want);
    if (got.write_enable !== want.write_enable)
      report_mismatch("write_enable", int'(got.write_enable), int'(want.write_enable));
    if (got.field_sel !== want.field_sel)
      report_mismatch("field_sel", int'(got.field_sel), int'(want.field_sel));
    if (got.position !== want.position)
      report_mismatch("position", int'(got.position), int'(want.position));
    if (got.char_out !== want.char_out)
      report_mismatch("char_out", int'(got.char_out), int'(want.char_out));
    if (got.close_field !== want.close_field)
      report_mismatch("close_field", int'(got.close_field), int'(want.close_field));
    if (got.clear_instance !== want.clear_instance)
      report_mismatch("clear_instance", int'(got.clear_instance),
                      int'(want.clear_instance));
    if (got.error !== want.error)
      report_mismatch("error", int'(got.error), int'(want.error));
    if (got.done_res !== want.done_res)
      report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
  endtask

  // valid stays high across back-to-back transactions; idle_input drops it
  task automatic send_item(input logic [7:0] c, input logic eon);
    int gap;
    gap = fast_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= c;
    in_ch.end_of_name <= eon;
    do @(posedge clk);
    while (!in_ch.ready);
    expected_cmds.push_back(predict_split(c, eon));
    items_sent++;
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_field(ref logic [7:0] s[$], input int len, input bit dots_ok);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        s.push_back(pns_pkg::CH_ESCAPE);
        s.push_back(8'($urandom_range(0, 255)));
      end else if (dots_ok && $urandom_range(0, 9) == 0) begin
        s.push_back(pns_pkg::CH_DOT);
      end else begin
        s.push_back(plain_char());
      end
    end
  endtask

  task automatic send_principal(input bit broken, input bit long_fields);
    logic [7:0] s[$];
    int         pos;
    add_field(s, pick_len(long_fields), 1'b0);
    if (long_fields || $urandom_range(0, 2) != 0) begin
      s.push_back(pns_pkg::CH_DOT);
      add_field(s, pick_len(long_fields), 1'b1);
    end
    if (long_fields || $urandom_range(0, 3) != 0) begin
      s.push_back(pns_pkg::CH_AT);
      add_field(s, pick_len(long_fields), 1'b1);
    end
    if (broken && s.size() > 0) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0:       s.insert(pos, pns_pkg::CH_AT);
        1:       s.insert(pos, pns_pkg::CH_DOT);
        default: s[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    foreach (s[i]) send_item(s[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_noise();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 12);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       c = pns_pkg::CH_ESCAPE;
        1:       c = pns_pkg::CH_DOT;
        2:       c = pns_pkg::CH_AT;
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_item(c, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_basic_split();
    send_name("a.b@c");
    send_name("x@y");
    idle_input();
  endtask

  // escaped at sign, extreme bytes, dots kept in instance, escape left
  // pending at the end item
  task automatic test_escapes_and_extremes();
    send_item(pns_pkg::CH_ESCAPE, 1'b0);
    send_item(pns_pkg::CH_AT, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(pns_pkg::CH_DOT, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(pns_pkg::CH_DOT, 1'b0);
    send_item(pns_pkg::CH_AT, 1'b0);
    send_item(pns_pkg::CH_ESCAPE, 1'b0);
    send_item(8'hFF, 1'b1);
    idle_input();
  endtask

  task automatic test_error_cases();
    send_name(".");
    send_name("@");
    send_name("a@@");
    send_name("");
    idle_input();
  endtask

  task automatic test_output_backpressure();
    fast_mode = 1'b1;
    hold_requests++;
    send_principal(1'b0, 1'b1);
    fast_mode = 1'b0;
    idle_input();
  endtask

  task automatic test_random_names();
    int stop_at;
    int r;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      fast_mode = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) send_principal(1'b0, 1'b1);
      else if (r < 70) send_principal(1'b0, 1'b0);
      else if (r < 85) send_principal(1'b1, 1'b0);
      else send_noise();
    end
    fast_mode = 1'b0;
    idle_input();
  endtask

  // result side: random stalls, full-rate runs and requested long hold-offs
  initial begin
    int gap;
    int run;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_ch.ready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk);
        holds_done++;
      end else if (fast_mode) begin
        out_ch.ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(1, 16);
          repeat (run - 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mon_got.write_enable   = out_ch.write_enable;
      mon_got.field_sel      = out_ch.field_sel;
      mon_got.position       = out_ch.position;
      mon_got.char_out       = out_ch.char_out;
      mon_got.close_field    = out_ch.close_field;
      mon_got.clear_instance = out_ch.clear_instance;
      mon_got.error          = out_ch.error;
      mon_got.done_res       = out_ch.done_res;
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected transaction", int'(mon_got), 0);
      end else begin
        mon_want = expected_cmds.pop_front();
        check_result(mon_got, mon_want);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clear_parse();
    items_sent        = 0;
    mismatches        = 0;
    fast_mode         = 1'b0;
    hold_requests     = 0;
    holds_done        = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.char_in     <= 8'h00;
    in_ch.end_of_name <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_split();
    test_escapes_and_extremes();
    test_error_cases();
    test_output_backpressure();
    test_random_names();

    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
